/* design/lpg_pkg.sv */
// Shared constants, types and helpers of the lexicographic permutation generator.
package lpg_pkg;

    // Symbol count, element and index widths
    localparam int MaxSymbols = 8;
    localparam int OutElems   = 8;
    localparam int SymW       = 4;
    localparam int SizeW      = 4;
    localparam int IdxW       = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;
    localparam int DataW      = OutElems * SymW;
    localparam int InDataW    = 8;

    typedef logic [SymW-1:0]                  t_sym;
    typedef logic [IdxW-1:0]                  t_idx;
    typedef logic [SizeW-1:0]                 t_size;
    typedef logic [MaxSymbols-1:0][SymW-1:0]  t_order;

    // Write and reload commands from the sequencer to the order store
    typedef struct packed {
        logic  we;
        t_idx  wr_addr;
        t_sym  wr_data;
        logic  load_id;
        t_size id_size;
    } t_store_ctl;

    // Size written by the host: zero means one, too large saturates
    function automatic t_size clamp_size(input logic [SizeW-1:0] v);
        t_size r;
        if (v == '0) begin
            r = t_size'(1);
        end else if (v > t_size'(MaxSymbols)) begin
            r = t_size'(MaxSymbols);
        end else begin
            r = v;
        end
        return r;
    endfunction

    localparam t_size ResetSize = clamp_size(t_size'(8));

endpackage

/* design/lpg_regs.sv */
// Order store: symbol registers with one read port, one write port and identity reload.
module lpg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpg_pkg::t_store_ctl i_ctl,
    input  lpg_pkg::t_idx      i_rd_addr,
    output lpg_pkg::t_sym      o_rd_data,
    output lpg_pkg::t_order    o_order,
    output logic               o_desc
);
    import lpg_pkg::*;

    t_order r_order;
    logic   w_desc;

    // Identity 1..n, zero from position n on
    function automatic t_order identity(input t_size n);
        t_order o;
        for (int i = 0; i < MaxSymbols; i++) begin
            o[i] = (i < int'(n)) ? t_sym'(i + 1) : '0;
        end
        return o;
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= identity(ResetSize);
        end else if (i_ctl.load_id) begin
            r_order <= identity(i_ctl.id_size);
        end else if (i_ctl.we) begin
            r_order[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // Single read port for the sequencer
    assign o_rd_data = r_order[i_rd_addr];

    // Descending when no adjacent pair ascends; unused tail is zero and never ascends
    always_comb begin
        w_desc = 1'b1;
        for (int i = 0; i + 1 < MaxSymbols; i++) begin
            if (r_order[i] < r_order[i+1]) begin
                w_desc = 1'b0;
            end
        end
    end

    assign o_desc  = w_desc;
    assign o_order = r_order;

endmodule

/* design/lpg_seq.sv */
// Step sequencer: pivot scan, successor scan, swap and suffix reversal over one comparator.
module lpg_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [lpg_pkg::SizeW-1:0] i_cfg_data,
    output logic                o_cfg_ready,
    input  logic                i_req_valid,
    input  logic                i_req_bit,
    output logic                o_req_ready,
    input  lpg_pkg::t_sym       i_rd_data,
    output lpg_pkg::t_idx       o_rd_addr,
    output lpg_pkg::t_store_ctl o_ctl,
    input  logic                i_out_room,
    output logic                o_out_load
);
    import lpg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_LOAD,
        ST_PIV_SCAN,
        ST_SUCC,
        ST_SWAP,
        ST_REV_A,
        ST_REV_B,
        ST_REV_C,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    t_size  r_size, n_size;
    logic   r_fresh, n_fresh;
    t_idx   r_idx, n_idx;
    t_idx   r_piv, n_piv;
    t_idx   r_lo, n_lo;
    t_idx   r_hi, n_hi;
    t_sym   r_prev, n_prev;
    t_sym   r_pv, n_pv;
    t_sym   r_tmp, n_tmp;

    t_size  w_size_m1;
    t_idx   w_last;
    t_idx   w_lo_inc;
    t_idx   w_hi_dec;
    t_sym   w_cmp_a, w_cmp_b;
    logic   w_lt;

    assign w_size_m1 = r_size - t_size'(1);
    assign w_last    = w_size_m1[IdxW-1:0];
    assign w_lo_inc  = r_lo + t_idx'(1);
    assign w_hi_dec  = r_hi - t_idx'(1);

    // Shared comparator: a < b
    always_comb begin
        unique case (r_state)
            ST_SUCC: begin
                w_cmp_a = r_pv;
                w_cmp_b = i_rd_data;
            end
            default: begin
                w_cmp_a = i_rd_data;
                w_cmp_b = r_prev;
            end
        endcase
    end
    assign w_lt = w_cmp_a < w_cmp_b;

    // Handshakes
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_req_ready = (r_state == ST_IDLE) && !i_cfg_valid;

    // Read address
    always_comb begin
        unique case (r_state)
            ST_REV_A: o_rd_addr = r_lo;
            ST_REV_B: o_rd_addr = r_hi;
            default:  o_rd_addr = r_idx;
        endcase
    end

    // Next state, store commands
    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_fresh    = r_fresh;
        n_idx      = r_idx;
        n_piv      = r_piv;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_prev     = r_prev;
        n_pv       = r_pv;
        n_tmp      = r_tmp;
        o_ctl      = '0;
        o_out_load = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_size        = clamp_size(i_cfg_data);
                    n_fresh       = 1'b1;
                    o_ctl.load_id = 1'b1;
                    o_ctl.id_size = clamp_size(i_cfg_data);
                end else if (i_req_valid && i_req_bit) begin
                    if (r_fresh) begin
                        n_fresh = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = w_last;
                        n_state = ST_PIV_LOAD;
                    end
                end
            end
            ST_PIV_LOAD: begin
                n_prev = i_rd_data;
                if (r_idx == '0) begin
                    o_ctl.load_id = 1'b1;
                    o_ctl.id_size = r_size;
                    n_state       = ST_DONE;
                end else begin
                    n_idx   = r_idx - t_idx'(1);
                    n_state = ST_PIV_SCAN;
                end
            end
            ST_PIV_SCAN: begin
                if (w_lt) begin
                    n_piv   = r_idx;
                    n_pv    = i_rd_data;
                    n_idx   = w_last;
                    n_state = ST_SUCC;
                end else if (r_idx == '0) begin
                    // last ordering reached: wrap to identity
                    o_ctl.load_id = 1'b1;
                    o_ctl.id_size = r_size;
                    n_state       = ST_DONE;
                end else begin
                    n_prev = i_rd_data;
                    n_idx  = r_idx - t_idx'(1);
                end
            end
            ST_SUCC: begin
                // rightmost symbol above the pivot value takes the pivot value
                if (w_lt) begin
                    o_ctl.we      = 1'b1;
                    o_ctl.wr_addr = r_idx;
                    o_ctl.wr_data = r_pv;
                    n_tmp         = i_rd_data;
                    n_state       = ST_SWAP;
                end else begin
                    n_idx = r_idx - t_idx'(1);
                end
            end
            ST_SWAP: begin
                o_ctl.we      = 1'b1;
                o_ctl.wr_addr = r_piv;
                o_ctl.wr_data = r_tmp;
                n_lo          = r_piv + t_idx'(1);
                n_hi          = w_last;
                if ((r_piv + t_idx'(1)) < w_last) begin
                    n_state = ST_REV_A;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REV_A: begin
                n_tmp   = i_rd_data;
                n_state = ST_REV_B;
            end
            ST_REV_B: begin
                o_ctl.we      = 1'b1;
                o_ctl.wr_addr = r_hi;
                o_ctl.wr_data = r_tmp;
                n_tmp         = i_rd_data;
                n_state       = ST_REV_C;
            end
            ST_REV_C: begin
                o_ctl.we      = 1'b1;
                o_ctl.wr_addr = r_lo;
                o_ctl.wr_data = r_tmp;
                n_lo          = w_lo_inc;
                n_hi          = w_hi_dec;
                if (w_lo_inc < w_hi_dec) begin
                    n_state = ST_REV_A;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_room) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_size  <= ResetSize;
            r_fresh <= 1'b1;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_fresh <= n_fresh;
        end
        r_idx  <= n_idx;
        r_piv  <= n_piv;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_prev <= n_prev;
        r_pv   <= n_pv;
        r_tmp  <= n_tmp;
    end

endmodule

/* design/lexicographic_permutation_generator.sv */
// Top level of the lexicographic permutation generator: sequencer, order store, output register.
//
//  channel   direction  payload                                   accepted when
//  s_axis    in         tdata[0] next_request                     tvalid & tready
//  m_axis    out        tdata elem_0..elem_7, tlast is_last       tvalid & tready
//  cfg       in         i_cfg_data set_size                       i_cfg_valid & o_cfg_ready
//
// A request with next_request clear is taken and gives no item.
// The first request after reset or a size write gives the loaded identity; a later
// one runs the pivot scan, the successor scan, the swap and the suffix reversal in turn,
// serialised by the single read port of the order store and the one shared comparator.
// Reset (synchronous, active low) loads the identity of 8 symbols; a size write
// reloads the identity. The output register holds an item while m_axis_tready is low;
// the next request is taken meanwhile and its result waits in the sequencer until the
// register frees.
module lexicographic_permutation_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // next_request in bit 0
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpg_pkg::InDataW-1:0]   s_axis_tdata,
    // elem_0 [3:0], elem_1 [7:4], ... elem_7 [31:28]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpg_pkg::DataW-1:0]     m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpg_pkg::SizeW-1:0]     i_cfg_data
);
    import lpg_pkg::*;

    t_store_ctl w_ctl;
    t_idx       w_rd_addr;
    t_sym       w_rd_data;
    t_order     w_order;
    logic       w_desc;
    logic       w_out_room;
    logic       w_out_load;
    logic [DataW-1:0] w_elems;

    logic             r_tvalid;
    logic [DataW-1:0] r_tdata;
    logic             r_tlast;

    assign w_out_room = !r_tvalid || m_axis_tready;

    lpg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_req_valid (s_axis_tvalid),
        .i_req_bit   (s_axis_tdata[0]),
        .o_req_ready (s_axis_tready),
        .i_rd_data   (w_rd_data),
        .o_rd_addr   (w_rd_addr),
        .o_ctl       (w_ctl),
        .i_out_room  (w_out_room),
        .o_out_load  (w_out_load)
    );

    lpg_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_order   (w_order),
        .o_desc    (w_desc)
    );

    // Pack reported positions; positions past the store read zero
    for (genvar g = 0; g < OutElems; g++) begin : g_pack
        if (g < MaxSymbols) begin : g_used
            assign w_elems[g*SymW +: SymW] = w_order[g];
        end else begin : g_zero
            assign w_elems[g*SymW +: SymW] = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
        if (w_out_load) begin
            r_tdata <= w_elems;
            r_tlast <= w_desc;
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the lexicographic permutation generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    localparam int ClkHalf     = 6;
    localparam int ResetCycles = 6;
    localparam int TargetItems = 1800;
    localparam int SettleCyc   = 32;
    localparam int DrainCyc    = 40;
    localparam int StallLimit  = 4000;
    localparam bit REQ_NEXT    = 1'b1;
    localparam bit REQ_NONE    = 1'b0;

    // One expected permutation as it appears on m_axis
    typedef struct {
        t_order elems;
        logic   last;
    } t_perm_item;

    // Tracks the permutation the block should be on and checks each result
    class perm_tracker;
        t_sym         order[MaxSymbols];
        bit           fresh;
        int unsigned  n_syms;
        t_perm_item   expected_perms[$];
        int unsigned  errors;

        function void load_identity();
            for (int i = 0; i < MaxSymbols; i++) begin
                order[i] = (i < n_syms) ? t_sym'(i + 1) : t_sym'(0);
            end
            fresh = 1'b1;
        endfunction

        // Size write: zero acts as one, oversize saturates
        function void set_size(logic [SizeW-1:0] v);
            if (v == 0) begin
                n_syms = 1;
            end else if (v > MaxSymbols) begin
                n_syms = MaxSymbols;
            end else begin
                n_syms = 32'(v);
            end
            load_identity();
        endfunction

        function bit is_descending();
            for (int i = 0; i + 1 < n_syms; i++) begin
                if (order[i] < order[i + 1]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Next permutation: rightmost ascent, swap with rightmost larger, reverse tail
        function void advance_order();
            int   pivot;
            int   succ;
            int   lo;
            int   hi;
            t_sym tmp;
            pivot = -1;
            for (int i = 0; i + 1 < n_syms; i++) begin
                if (order[i] < order[i + 1]) pivot = i;
            end
            if (pivot < 0) begin
                load_identity();
                fresh = 1'b0;
                return;
            end
            succ = pivot + 1;
            for (int i = pivot + 1; i < n_syms; i++) begin
                if (order[i] > order[pivot]) succ = i;
            end
            tmp          = order[pivot];
            order[pivot] = order[succ];
            order[succ]  = tmp;
            lo = pivot + 1;
            hi = n_syms - 1;
            while (lo < hi) begin
                tmp       = order[lo];
                order[lo] = order[hi];
                order[hi] = tmp;
                lo++;
                hi--;
            end
        endfunction

        function void note_request(bit req);
            t_perm_item p;
            if (!req) return;
            if (fresh) fresh = 1'b0;
            else advance_order();
            for (int i = 0; i < OutElems; i++) begin
                p.elems[i] = (i < n_syms) ? order[i] : t_sym'(0);
            end
            p.last = is_descending();
            expected_perms.insert(expected_perms.size(), p);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_perm(logic [DataW-1:0] data, logic last);
            t_perm_item p;
            t_order     got;
            if (expected_perms.size() == 0) begin
                report_mismatch($sformatf("unexpected item data=%h last=%b", data, last));
                return;
            end
            p   = expected_perms.pop_front();
            got = data;
            for (int i = 0; i < OutElems; i++) begin
                if (got[i] !== p.elems[i]) begin
                    report_mismatch($sformatf("elem_%0d got %0d want %0d (n=%0d)",
                                              i, got[i], p.elems[i], n_syms));
                end
            end
            if (last !== p.last) begin
                report_mismatch($sformatf("is_last got %b want %b, data=%h",
                                          last, p.last, data));
            end
        endtask

        function int unsigned pending();
            return expected_perms.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata   = '0;   // next_request [0], zero fill [7:1]
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [DataW-1:0]    m_axis_tdata;          // elem_0 [3:0] ... elem_7 [31:28]
    logic                m_axis_tlast;          // is_last
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [SizeW-1:0]    i_cfg_data     = '0;   // set_size

    perm_tracker tracker = new();
    bit          calm;
    int          ready_hold;
    int          stall_cycles;
    int          items_sent;

    lexicographic_permutation_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #ClkHalf i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output back-pressure
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= 8;
        end else if ($urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                          : $urandom_range(0, 3);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_perm(m_axis_tdata, m_axis_tlast);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Send one request item; starts and returns on a falling edge
    task automatic send_item(bit req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-1){1'b0}}, req};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(req);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_requests(int count);
        for (int k = 0; k < count; k++) begin
            send_item(REQ_NEXT);
        end
    endtask

    // Size write once all results are out and the block has settled
    task automatic write_size(logic [SizeW-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SettleCyc) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_size(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= t_size'($urandom_range(0, 15));
    endtask

    // Sizes lean small so that full cycles and wraps come often
    function automatic logic [SizeW-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return t_size'($urandom_range(1, 5));
        if (r < 16) return t_size'($urandom_range(6, 7));
        if (r < 18) return ($urandom_range(0, 1) != 0) ? 4'd8 : 4'd0;
        return t_size'($urandom_range(9, 15));
    endfunction

    initial begin
        int burst;
        tracker.set_size(4'd8);
        calm = 1'b0;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset size, ignored request, one symbol, zero and oversize
        // writes, a full cycle with wrap, two symbols
        send_item(REQ_NONE);
        send_requests(3);
        send_item(REQ_NONE);
        write_size(4'd1);
        send_requests(2);
        write_size(4'd0);
        send_requests(1);
        write_size(4'd15);
        send_requests(2);
        write_size(4'd3);
        send_requests(7);
        write_size(4'd2);
        send_requests(3);

        // Random phases of requests, mostly after a fresh size write
        while (items_sent < TargetItems) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) write_size(pick_size());
            burst = $urandom_range(10, 120);
            for (int k = 0; k < burst; k++) begin
                send_item(($urandom_range(0, 9) != 0) ? REQ_NEXT : REQ_NONE);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (DrainCyc) @(negedge i_clk);
        if (tracker.pending() != 0) begin
            tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        end
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/lpg_pkg.sv
design/lpg_regs.sv
design/lpg_seq.sv
design/lexicographic_permutation_generator.sv
tb/tb.sv
